@@ design/bpmc_pkg.sv @@
// ============================================================================
// Battery pack mode controller package
// Shared event, mode and indicator codes, and the structs that carry the
// controller state, the condition flags and the command pulses.
// ============================================================================
package bpmc_pkg;

    // Event codes carried in the input tuser field.
    typedef enum logic [2:0] {
        EV_TEMP      = 3'd0,
        EV_VOLT      = 3'd1,
        EV_IGN_ON    = 3'd2,
        EV_IGN_OFF   = 3'd3,
        EV_CHG_START = 3'd4,
        EV_CHG_END   = 3'd5,
        EV_ESTOP     = 3'd6,
        EV_UNKNOWN   = 3'd7
    } event_t;

    // Operating modes of the pack.
    typedef enum logic [2:0] {
        MODE_STANDBY  = 3'd0,
        MODE_DRIVE    = 3'd1,
        MODE_CHARGING = 3'd2,
        MODE_EMPTY    = 3'd3,
        MODE_OVERTEMP = 3'd4,
        MODE_ILLEGAL  = 3'd5
    } mode_t;

    // Status light codes.
    typedef enum logic [1:0] {
        LIGHT_STANDBY  = 2'd0,
        LIGHT_DRIVE    = 2'd1,
        LIGHT_CHARGING = 2'd2,
        LIGHT_FAULT    = 2'd3
    } light_t;

    // Battery condition flags, listed from the highest bit down as on tdata.
    typedef struct packed {
        logic charge_enable_on;
        logic ignition_on;
        logic too_cold;
        logic contactors_held;
        logic packs_imbalanced;
        logic cell_full;
        logic cell_empty;
        logic over_temperature;
    } flags_t;

    // Persistent controller state, listed from the highest bit down as on tdata.
    typedef struct packed {
        logic   heater_flag;
        logic   charge_block;
        logic   drive_block;
        light_t light_mode;
        mode_t  mode;
    } ctrl_state_t;

    // Commands that go with a result.
    typedef struct packed {
        logic unknown_event;
        logic shunt_reset;
        logic recompute_current;
        logic release_for_charge;
        logic release_for_drive;
        logic hold_all_contactors;
    } pulses_t;

    localparam ctrl_state_t STATE_RESET = '{
        heater_flag:  1'b0,
        charge_block: 1'b0,
        drive_block:  1'b0,
        light_mode:   LIGHT_STANDBY,
        mode:         MODE_STANDBY
    };

endpackage

@@ design/bpmc_decide.sv @@
// ============================================================================
// Battery pack mode decision logic
// Combinational transition logic: from the current state, one event code and
// the condition flags it gives the next state and the command pulses.
// ============================================================================
module bpmc_decide
    import bpmc_pkg::*;
(
    input  event_t      op,
    input  flags_t      flags,
    input  ctrl_state_t cur,
    output ctrl_state_t nxt,
    output pulses_t     pulse
);

    logic is_level_event;
    logic hot_temp;

    assign is_level_event = (op == EV_TEMP) || (op == EV_VOLT);
    assign hot_temp       = (op == EV_TEMP) && flags.over_temperature;

    // Mode transitions and flag updates.
    always_comb
    begin
        nxt   = cur;
        pulse = '0;
        unique case (op)
            EV_UNKNOWN:
            begin
                pulse.unknown_event = 1'b1;
            end
            EV_ESTOP:
            begin
                // Emergency stop takes no action here.
            end
            default:
            begin
                unique case (cur.mode)
                    MODE_STANDBY:
                    begin
                        if (hot_temp)
                        begin
                            nxt.drive_block  = 1'b1;
                            nxt.charge_block = 1'b1;
                            nxt.mode         = MODE_OVERTEMP;
                            nxt.light_mode   = LIGHT_FAULT;
                        end
                        else if (is_level_event)
                        begin
                            if (flags.cell_empty)
                            begin
                                nxt.drive_block = 1'b1;
                                nxt.mode        = MODE_EMPTY;
                                nxt.light_mode  = LIGHT_FAULT;
                            end
                            else if (flags.packs_imbalanced)
                            begin
                                pulse.hold_all_contactors = 1'b1;
                            end
                        end
                        else if (op == EV_IGN_ON)
                        begin
                            pulse.release_for_drive = flags.contactors_held;
                            nxt.mode                = MODE_DRIVE;
                            nxt.light_mode          = LIGHT_DRIVE;
                        end
                        else if (op == EV_CHG_START)
                        begin
                            if (flags.too_cold)
                            begin
                                nxt.heater_flag  = 1'b1;
                                nxt.charge_block = 1'b1;
                            end
                            nxt.mode       = MODE_CHARGING;
                            nxt.light_mode = LIGHT_CHARGING;
                        end
                    end
                    MODE_DRIVE:
                    begin
                        if (hot_temp)
                        begin
                            nxt.drive_block  = 1'b1;
                            nxt.charge_block = 1'b1;
                            nxt.mode         = MODE_OVERTEMP;
                            nxt.light_mode   = LIGHT_FAULT;
                        end
                        else if (is_level_event)
                        begin
                            if (flags.cell_empty)
                            begin
                                nxt.drive_block = 1'b1;
                                nxt.mode        = MODE_EMPTY;
                                nxt.light_mode  = LIGHT_FAULT;
                            end
                            else if (flags.contactors_held)
                            begin
                                pulse.release_for_drive = 1'b1;
                            end
                        end
                        else if (op == EV_IGN_OFF)
                        begin
                            nxt.mode       = MODE_STANDBY;
                            nxt.light_mode = LIGHT_STANDBY;
                        end
                        else if (op == EV_CHG_START)
                        begin
                            nxt.drive_block = 1'b1;
                            if (flags.contactors_held)
                            begin
                                nxt.charge_block = 1'b1;
                                nxt.mode         = MODE_ILLEGAL;
                                nxt.light_mode   = LIGHT_FAULT;
                            end
                            else
                            begin
                                nxt.mode       = MODE_CHARGING;
                                nxt.light_mode = LIGHT_CHARGING;
                            end
                        end
                    end
                    MODE_CHARGING:
                    begin
                        if (op == EV_TEMP)
                        begin
                            if (flags.over_temperature)
                            begin
                                nxt.drive_block  = 1'b1;
                                nxt.charge_block = 1'b1;
                                nxt.mode         = MODE_OVERTEMP;
                                nxt.light_mode   = LIGHT_FAULT;
                            end
                            else
                            begin
                                // Heater control: turn off once warm, on when cold.
                                if (cur.heater_flag && !flags.too_cold)
                                begin
                                    nxt.heater_flag  = 1'b0;
                                    nxt.charge_block = 1'b0;
                                end
                                if (!nxt.heater_flag && flags.too_cold)
                                begin
                                    nxt.heater_flag  = 1'b1;
                                    nxt.charge_block = 1'b1;
                                end
                                pulse.recompute_current = 1'b1;
                            end
                        end
                        else if (op == EV_VOLT)
                        begin
                            if (flags.cell_full)
                            begin
                                nxt.charge_block = 1'b1;
                            end
                        end
                        else if (op == EV_IGN_ON)
                        begin
                            nxt.drive_block = 1'b1;
                        end
                        else if (op == EV_IGN_OFF)
                        begin
                            nxt.drive_block = 1'b0;
                        end
                        else if (op == EV_CHG_END)
                        begin
                            nxt.heater_flag  = 1'b0;
                            nxt.charge_block = 1'b0;
                            nxt.drive_block  = 1'b0;
                            if (flags.cell_empty)
                            begin
                                nxt.drive_block = 1'b1;
                                nxt.mode        = MODE_EMPTY;
                                nxt.light_mode  = LIGHT_FAULT;
                            end
                            else
                            begin
                                pulse.shunt_reset = flags.cell_full;
                                if (flags.ignition_on)
                                begin
                                    nxt.mode       = MODE_DRIVE;
                                    nxt.light_mode = LIGHT_DRIVE;
                                end
                                else
                                begin
                                    nxt.mode       = MODE_STANDBY;
                                    nxt.light_mode = LIGHT_STANDBY;
                                end
                            end
                        end
                    end
                    MODE_EMPTY:
                    begin
                        if (hot_temp)
                        begin
                            nxt.drive_block  = 1'b1;
                            nxt.charge_block = 1'b1;
                            nxt.mode         = MODE_OVERTEMP;
                            nxt.light_mode   = LIGHT_FAULT;
                        end
                        else if (is_level_event)
                        begin
                            if (!flags.cell_empty)
                            begin
                                nxt.drive_block = 1'b0;
                                if (flags.ignition_on)
                                begin
                                    pulse.release_for_drive = flags.contactors_held;
                                    nxt.mode                = MODE_DRIVE;
                                    nxt.light_mode          = LIGHT_DRIVE;
                                end
                                else
                                begin
                                    nxt.mode       = MODE_STANDBY;
                                    nxt.light_mode = LIGHT_STANDBY;
                                end
                            end
                        end
                        else if (op == EV_IGN_ON)
                        begin
                            nxt.drive_block = 1'b1;
                        end
                        else if (op == EV_CHG_START)
                        begin
                            if (flags.too_cold)
                            begin
                                nxt.heater_flag  = 1'b1;
                                nxt.charge_block = 1'b1;
                            end
                            nxt.mode       = MODE_CHARGING;
                            nxt.light_mode = LIGHT_CHARGING;
                        end
                    end
                    MODE_OVERTEMP:
                    begin
                        // Charge enable wins over the ignition when cooled down.
                        if ((op == EV_TEMP) && !flags.over_temperature)
                        begin
                            nxt.charge_block = 1'b0;
                            if (flags.charge_enable_on)
                            begin
                                pulse.release_for_charge = flags.contactors_held;
                                nxt.mode                 = MODE_CHARGING;
                                nxt.light_mode           = LIGHT_CHARGING;
                            end
                            else if (flags.ignition_on)
                            begin
                                pulse.release_for_drive = flags.contactors_held;
                                nxt.drive_block         = 1'b0;
                                nxt.mode                = MODE_DRIVE;
                                nxt.light_mode          = LIGHT_DRIVE;
                            end
                            else
                            begin
                                nxt.drive_block = 1'b0;
                                nxt.mode        = MODE_STANDBY;
                                nxt.light_mode  = LIGHT_STANDBY;
                            end
                        end
                    end
                    MODE_ILLEGAL:
                    begin
                        // The light and the inhibit flags stay as they are.
                        if ((op == EV_IGN_OFF) && !flags.charge_enable_on)
                        begin
                            nxt.mode = MODE_STANDBY;
                        end
                        else if ((op == EV_CHG_END) && !flags.ignition_on)
                        begin
                            nxt.mode = MODE_STANDBY;
                        end
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
        endcase
    end

endmodule

@@ design/battery_pack_mode_controller.sv @@
// ============================================================================
// Battery pack mode controller
// Event-driven six-mode controller for a battery pack with contactor, heater
// and shunt command pulses. One result transaction for every event.
// ============================================================================
// An accepted event waits in the event register and moves on to the result
// register when that is free; the result is then on the master side.
// Throughput: one event per cycle unless the result side stalls; the mode
// decision is one pass of logic between the event and result registers.
// Reset (rst_n low, asynchronous): mode standby, light standby, all inhibit
// and heater flags clear, no event held and no result pending.
module battery_pack_mode_controller
    import bpmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] over_temperature, [1] cell_empty, [2] cell_full, [3] packs_imbalanced,
    // [4] contactors_held, [5] too_cold, [6] ignition_on, [7] charge_enable_on
    input  logic [7:0]  s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] mode, [4:3] indicator_mode, [5] drive_inhibit, [6] charge_inhibit,
    // [7] heater_on, [8] hold_all_contactors, [9] release_for_drive,
    // [10] release_for_charge, [11] recompute_current, [12] shunt_reset,
    // [13] unknown_event, [15:14] zero
    output logic [15:0] m_axis_tdata
);

    logic        ev_valid_reg;
    event_t      ev_op_reg;
    flags_t      ev_flags_reg;
    logic        out_valid_reg;
    ctrl_state_t out_state_reg;
    pulses_t     out_pulse_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    pulses_t     pulse_next;
    logic        in_take;
    logic        out_load;

    // Handshake: the held event moves on when the result register is free.
    assign out_load      = ev_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !ev_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Event register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            ev_valid_reg <= s_axis_tvalid;
        end
    end

    // Event register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_op_reg    <= event_t'(s_axis_tuser);
            ev_flags_reg <= flags_t'(s_axis_tdata);
        end
    end

    // Transition logic.
    bpmc_decide u_decide (
        .op    (ev_op_reg),
        .flags (ev_flags_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .pulse (pulse_next)
    );

    // Controller state advances once per event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (out_load)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_state_reg <= state_next;
            out_pulse_reg <= pulse_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_pulse_reg, out_state_reg};

    // An unknown event leaves the controller state untouched.
    a_unknown_keeps_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_load && (ev_op_reg == EV_UNKNOWN)) |=> (state_reg == $past(state_reg))
    ) else $error("unknown event changed the controller state");

    // The over-temperature mode always shows the fault light.
    a_overtemp_light: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_OVERTEMP) |-> (state_reg.light_mode == LIGHT_FAULT)
    ) else $error("over-temperature mode without fault light");

    // A held event that cannot move on stays held.
    a_event_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && !out_load) |=> ev_valid_reg
    ) else $error("held event dropped while the result register was busy");

    // Drive and charge releases never go out in the same result.
    a_release_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_pulse_reg.release_for_drive && out_pulse_reg.release_for_charge)
    ) else $error("drive and charge releases issued together");

    // The state only moves when a result is loaded.
    a_state_moves_on_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(state_reg)
    ) else $error("controller state changed without an event");

endmodule

@@ bench/battery_pack_mode_controller_test.sv @@
// ============================================================================
// Battery pack mode controller testbench
// Drives event transactions with condition flags into the controller and
// checks every result transaction against a cycle-free model of the six-mode
// state machine, under random stalls on both sides and one long output stall.
// ============================================================================
module battery_pack_mode_controller_test
    import bpmc_pkg::*;
;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PERCENT = 11;
    localparam int HOLD_CYCLES  = 80;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 5;

    // Condition flag bits as they sit on s_axis_tdata.
    localparam logic [7:0] F_HOT   = 8'h01;
    localparam logic [7:0] F_EMPTY = 8'h02;
    localparam logic [7:0] F_FULL  = 8'h04;
    localparam logic [7:0] F_IMBAL = 8'h08;
    localparam logic [7:0] F_HELD  = 8'h10;
    localparam logic [7:0] F_COLD  = 8'h20;
    localparam logic [7:0] F_IGN   = 8'h40;
    localparam logic [7:0] F_CHG   = 8'h80;

    // Result transaction layout, lowest bits first: state, then command pulses.
    typedef struct packed {
        logic [1:0]  pad;
        pulses_t     cmd;
        ctrl_state_t st;
    } outcome_t;

    // Model of the mode controller and the queue of results it still owes.
    class mode_scoreboard;
        ctrl_state_t st;
        outcome_t    owed_q[$];
        int          mismatches;
        int          results_seen;

        function new();
            st = STATE_RESET;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // Advance the model by one accepted event and queue the result it owes.
        function void note_event(event_t op, flags_t f);
            ctrl_state_t s;
            pulses_t     p;
            outcome_t    r;
            s = st;
            p = '0;
            if (op == EV_UNKNOWN)
            begin
                p.unknown_event = 1'b1;
            end
            else if (op == EV_ESTOP)
            begin
                // An emergency stop changes nothing here.
            end
            else if (op == EV_TEMP && f.over_temperature &&
                     s.mode inside {MODE_STANDBY, MODE_DRIVE, MODE_CHARGING, MODE_EMPTY})
            begin
                s.drive_block = 1'b1;
                s.charge_block = 1'b1;
                s.mode = MODE_OVERTEMP;
                s.light_mode = LIGHT_FAULT;
            end
            else
            begin
                case (s.mode)
                    MODE_STANDBY:
                    begin
                        if (op == EV_TEMP || op == EV_VOLT)
                        begin
                            if (f.cell_empty)
                            begin
                                s.drive_block = 1'b1;
                                s.mode = MODE_EMPTY;
                                s.light_mode = LIGHT_FAULT;
                            end
                            else if (f.packs_imbalanced)
                                p.hold_all_contactors = 1'b1;
                        end
                        else if (op == EV_IGN_ON)
                        begin
                            p.release_for_drive = f.contactors_held;
                            s.mode = MODE_DRIVE;
                            s.light_mode = LIGHT_DRIVE;
                        end
                        else if (op == EV_CHG_START)
                        begin
                            if (f.too_cold)
                            begin
                                s.heater_flag = 1'b1;
                                s.charge_block = 1'b1;
                            end
                            s.mode = MODE_CHARGING;
                            s.light_mode = LIGHT_CHARGING;
                        end
                    end
                    MODE_DRIVE:
                    begin
                        if (op == EV_TEMP || op == EV_VOLT)
                        begin
                            if (f.cell_empty)
                            begin
                                s.drive_block = 1'b1;
                                s.mode = MODE_EMPTY;
                                s.light_mode = LIGHT_FAULT;
                            end
                            else
                                p.release_for_drive = f.contactors_held;
                        end
                        else if (op == EV_IGN_OFF)
                        begin
                            s.mode = MODE_STANDBY;
                            s.light_mode = LIGHT_STANDBY;
                        end
                        else if (op == EV_CHG_START)
                        begin
                            s.drive_block = 1'b1;
                            if (f.contactors_held)
                            begin
                                s.charge_block = 1'b1;
                                s.mode = MODE_ILLEGAL;
                                s.light_mode = LIGHT_FAULT;
                            end
                            else
                            begin
                                s.mode = MODE_CHARGING;
                                s.light_mode = LIGHT_CHARGING;
                            end
                        end
                    end
                    MODE_CHARGING:
                    begin
                        if (op == EV_TEMP)
                        begin
                            // The heater follows the cold flag; the current is recomputed.
                            if (s.heater_flag && !f.too_cold)
                            begin
                                s.heater_flag = 1'b0;
                                s.charge_block = 1'b0;
                            end
                            if (!s.heater_flag && f.too_cold)
                            begin
                                s.heater_flag = 1'b1;
                                s.charge_block = 1'b1;
                            end
                            p.recompute_current = 1'b1;
                        end
                        else if (op == EV_VOLT)
                        begin
                            if (f.cell_full)
                                s.charge_block = 1'b1;
                        end
                        else if (op == EV_IGN_ON)
                            s.drive_block = 1'b1;
                        else if (op == EV_IGN_OFF)
                            s.drive_block = 1'b0;
                        else if (op == EV_CHG_END)
                        begin
                            s.heater_flag = 1'b0;
                            s.charge_block = 1'b0;
                            s.drive_block = 1'b0;
                            if (f.cell_empty)
                            begin
                                s.drive_block = 1'b1;
                                s.mode = MODE_EMPTY;
                                s.light_mode = LIGHT_FAULT;
                            end
                            else
                            begin
                                p.shunt_reset = f.cell_full;
                                if (f.ignition_on)
                                begin
                                    s.mode = MODE_DRIVE;
                                    s.light_mode = LIGHT_DRIVE;
                                end
                                else
                                begin
                                    s.mode = MODE_STANDBY;
                                    s.light_mode = LIGHT_STANDBY;
                                end
                            end
                        end
                    end
                    MODE_EMPTY:
                    begin
                        if (op == EV_TEMP || op == EV_VOLT)
                        begin
                            if (!f.cell_empty)
                            begin
                                s.drive_block = 1'b0;
                                if (f.ignition_on)
                                begin
                                    p.release_for_drive = f.contactors_held;
                                    s.mode = MODE_DRIVE;
                                    s.light_mode = LIGHT_DRIVE;
                                end
                                else
                                begin
                                    s.mode = MODE_STANDBY;
                                    s.light_mode = LIGHT_STANDBY;
                                end
                            end
                        end
                        else if (op == EV_IGN_ON)
                            s.drive_block = 1'b1;
                        else if (op == EV_CHG_START)
                        begin
                            if (f.too_cold)
                            begin
                                s.charge_block = 1'b1;
                                s.heater_flag = 1'b1;
                            end
                            s.mode = MODE_CHARGING;
                            s.light_mode = LIGHT_CHARGING;
                        end
                    end
                    MODE_OVERTEMP:
                    begin
                        // Only a cool temperature reading leaves; charge enable wins.
                        if (op == EV_TEMP && !f.over_temperature)
                        begin
                            if (f.charge_enable_on)
                            begin
                                p.release_for_charge = f.contactors_held;
                                s.charge_block = 1'b0;
                                s.mode = MODE_CHARGING;
                                s.light_mode = LIGHT_CHARGING;
                            end
                            else if (f.ignition_on)
                            begin
                                p.release_for_drive = f.contactors_held;
                                s.charge_block = 1'b0;
                                s.drive_block = 1'b0;
                                s.mode = MODE_DRIVE;
                                s.light_mode = LIGHT_DRIVE;
                            end
                            else
                            begin
                                s.drive_block = 1'b0;
                                s.charge_block = 1'b0;
                                s.mode = MODE_STANDBY;
                                s.light_mode = LIGHT_STANDBY;
                            end
                        end
                    end
                    MODE_ILLEGAL:
                    begin
                        // Leaving the illegal fault touches the mode alone.
                        if (op == EV_IGN_OFF && !f.charge_enable_on)
                            s.mode = MODE_STANDBY;
                        else if (op == EV_CHG_END && !f.ignition_on)
                            s.mode = MODE_STANDBY;
                    end
                    default:
                    begin
                    end
                endcase
            end
            st = s;
            r.pad = '0;
            r.cmd = p;
            r.st = s;
            owed_q.push_back(r);
        endfunction

        function void report(string what, int exp_v, int act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, what, exp_v, act_v);
        endfunction

        function void compare(string what, int exp_v, int act_v);
            if (exp_v != act_v)
                report(what, exp_v, act_v);
        endfunction

        // Compare one accepted result transaction with the oldest owed result.
        function void check_result(logic [15:0] data);
            outcome_t e;
            outcome_t a;
            a = outcome_t'(data);
            results_seen++;
            if (owed_q.size() == 0)
            begin
                report("result with nothing owed, tdata", 0, data);
                return;
            end
            e = owed_q.pop_front();
            compare("mode", e.st.mode, a.st.mode);
            compare("indicator_mode", e.st.light_mode, a.st.light_mode);
            compare("drive_inhibit", e.st.drive_block, a.st.drive_block);
            compare("charge_inhibit", e.st.charge_block, a.st.charge_block);
            compare("heater_on", e.st.heater_flag, a.st.heater_flag);
            compare("hold_all_contactors", e.cmd.hold_all_contactors,
                    a.cmd.hold_all_contactors);
            compare("release_for_drive", e.cmd.release_for_drive, a.cmd.release_for_drive);
            compare("release_for_charge", e.cmd.release_for_charge, a.cmd.release_for_charge);
            compare("recompute_current", e.cmd.recompute_current, a.cmd.recompute_current);
            compare("shunt_reset", e.cmd.shunt_reset, a.cmd.shunt_reset);
            compare("unknown_event", e.cmd.unknown_event, a.cmd.unknown_event);
            compare("padding", e.pad, a.pad);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    logic        idling_on;
    logic        hold_request;
    mode_scoreboard sb;

    battery_pack_mode_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial
        clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Record every transaction on both sides at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_event(event_t'(s_axis_tuser), flags_t'(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Result receiver: random stalls, plus one long hold when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= !idling_on || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one event transaction; called at a falling edge, returns at one.
    task automatic send_event(event_t op, logic [7:0] flags);
        while (idling_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= flags;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random event, weighted toward the transitions that move the mode.
    task automatic send_random_event();
        int     pick;
        event_t op;
        flags_t f;
        pick = $urandom_range(99);
        if (pick < 20)      op = EV_TEMP;
        else if (pick < 40) op = EV_VOLT;
        else if (pick < 55) op = EV_IGN_ON;
        else if (pick < 70) op = EV_IGN_OFF;
        else if (pick < 82) op = EV_CHG_START;
        else if (pick < 94) op = EV_CHG_END;
        else if (pick < 97) op = EV_ESTOP;
        else                op = EV_UNKNOWN;
        f = flags_t'(8'($urandom_range(255)));
        // Hot and empty readings are rarer so that the normal modes get time.
        f.over_temperature = ($urandom_range(99) < 15);
        f.cell_empty = ($urandom_range(99) < 20);
        send_event(op, f);
    endtask

    // Stimulus and end of run.
    initial
    begin : stimulus
        int guard;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = EV_TEMP;
        idling_on = 1'b1;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk through every mode and every special case.
        send_event(EV_UNKNOWN, 8'hFF);
        send_event(EV_ESTOP, 8'hFF);
        send_event(EV_TEMP, F_IMBAL);
        send_event(EV_VOLT, F_EMPTY);
        send_event(EV_IGN_ON, F_IGN);
        send_event(EV_VOLT, F_IGN | F_HELD);
        send_event(EV_TEMP, F_HOT);
        send_event(EV_IGN_OFF, F_HOT);
        send_event(EV_TEMP, F_CHG | F_IGN | F_HELD);
        send_event(EV_TEMP, F_COLD);
        send_event(EV_TEMP, 8'h00);
        send_event(EV_VOLT, F_FULL);
        send_event(EV_IGN_ON, F_IGN);
        send_event(EV_IGN_OFF, 8'h00);
        send_event(EV_CHG_END, F_FULL | F_IGN);
        send_event(EV_CHG_START, F_HELD);
        send_event(EV_IGN_OFF, F_CHG);
        send_event(EV_CHG_END, F_IGN);
        send_event(EV_IGN_OFF, 8'h00);
        send_event(EV_IGN_ON, 8'h00);
        send_event(EV_TEMP, F_HOT);
        send_event(EV_TEMP, F_IGN | F_HELD);
        send_event(EV_IGN_OFF, 8'h00);
        send_event(EV_CHG_START, F_COLD);
        send_event(EV_CHG_END, F_EMPTY);

        // Random events with stalls on both sides.
        repeat (300) send_random_event();

        // A stretch with no stalls at all.
        idling_on = 1'b0;
        repeat (200) send_random_event();

        // Hold the output long enough for the controller to back up its input.
        idling_on = 1'b1;
        hold_request = 1'b1;
        repeat (300) send_random_event();
        s_axis_tvalid <= 1'b0;

        // Drain the owed results, then give the pipeline time to settle.
        guard = 0;
        while (sb.owed_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.owed_q.size() != 0)
            $display("%0d results never arrived", sb.owed_q.size());
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("battery_pack_mode_controller: match");
        else
            $display("battery_pack_mode_controller: mismatch");
        $finish;
    end

    // Hard stop if the run hangs.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("battery_pack_mode_controller: mismatch");
        $finish;
    end

endmodule
